// ===== rtl/md4_pkg.sv =====
// md4_pkg: shared constants, types and step functions for the MD4 digest block.
// Used by md4_buf, md4_core and md4_digest; no dependencies.
package md4_pkg;

    localparam int WORD_W  = 32;
    localparam int MSG_W   = 61;
    localparam int ADDR_W  = 4;
    localparam int FILL_W  = 5;
    localparam int STEP_W  = 6;

    localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
    localparam logic [WORD_W-1:0] INIT_B = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] INIT_C = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;
    localparam logic [WORD_W-1:0] K_R2   = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_R3   = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] PAD_WORD = 32'h00000080;

    localparam logic [STEP_W-1:0] LAST_STEP   = 6'd47;
    localparam logic [ADDR_W-1:0] LAST_ADDR   = 4'd15;
    localparam logic [ADDR_W-1:0] LEN_LO_ADDR = 4'd14;
    localparam logic [ADDR_W-1:0] LEN_HI_ADDR = 4'd15;
    localparam logic [FILL_W-1:0] FILL_NONE   = 5'd16;
    localparam logic [FILL_W-1:0] LEN_START   = 5'd14;
    localparam logic [2:0]        FULL_BYTES  = 3'd4;

    typedef logic [WORD_W-1:0]       t_word;
    typedef logic [3:0][WORD_W-1:0]  t_chain;

    // Command to the compression core: start a block, with words at or above
    // fill_start reading as zero and, if len_en, words 14/15 as the bit length.
    typedef struct packed {
        logic              start;
        logic [FILL_W-1:0] fill_start;
        logic              len_en;
    } t_core_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    // Message word used at step j.
    function automatic logic [ADDR_W-1:0] msg_index(input logic [STEP_W-1:0] j);
        logic [ADDR_W-1:0] r;
        unique case (j[5:4])
            2'd0:    r = j[3:0];
            2'd1:    r = {j[1:0], j[3:2]};
            default: r = {j[0], j[1], j[2], j[3]};
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [STEP_W-1:0] j);
        logic [4:0] r;
        unique case ({j[5:4], j[1:0]})
            4'b00_00, 4'b01_00, 4'b10_00: r = 5'd3;
            4'b00_01:                     r = 5'd7;
            4'b00_10, 4'b10_10:           r = 5'd11;
            4'b00_11:                     r = 5'd19;
            4'b01_01:                     r = 5'd5;
            4'b01_10, 4'b10_01:           r = 5'd9;
            4'b01_11:                     r = 5'd13;
            default:                      r = 5'd15;
        endcase
        return r;
    endfunction

    function automatic t_word rotl(input t_word x, input logic [4:0] s);
        return (x << s) | (x >> (6'd32 - {1'b0, s}));
    endfunction

    // Last word of a message: keep n bytes, append 0x80 right after them when n is below 4.
    function automatic t_word pad_last(input t_word d, input logic [2:0] n);
        t_word r;
        unique case (n)
            3'd0:    r = PAD_WORD;
            3'd1:    r = {16'h0000, 8'h80, d[7:0]};
            3'd2:    r = {8'h00, 8'h80, d[15:0]};
            3'd3:    r = {8'h80, d[23:0]};
            default: r = d;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/md4_buf.sv =====
// md4_buf: 16-word block buffer, one write and one read port, registered read.
// Depends on md4_pkg for widths.
module md4_buf (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [md4_pkg::ADDR_W-1:0]    i_waddr,
    input  md4_pkg::t_word                i_wdata,
    input  logic [md4_pkg::ADDR_W-1:0]    i_raddr,
    output md4_pkg::t_word                o_rdata
);

    md4_pkg::t_word r_mem [16];
    md4_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/md4_core.sv =====
// md4_core: 48-step MD4 compression, one step per cycle, reading the block
// buffer one word ahead. Holds chaining and working words. Depends on md4_pkg.
module md4_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  md4_pkg::t_core_cmd            i_cmd,
    input  logic                          i_init,
    input  md4_pkg::t_word                i_len_lo,
    input  md4_pkg::t_word                i_len_hi,
    input  md4_pkg::t_word                i_rdata,
    output logic [md4_pkg::ADDR_W-1:0]    o_raddr,
    output md4_pkg::t_core_sts            o_sts,
    output md4_pkg::t_chain               o_chain
);

    logic                          r_busy;
    logic                          r_fin;
    logic [md4_pkg::STEP_W-1:0]    r_step;
    logic [md4_pkg::ADDR_W-1:0]    r_idx;
    logic [md4_pkg::FILL_W-1:0]    r_fill;
    logic                          r_len;
    md4_pkg::t_chain               r_chain;
    md4_pkg::t_word                r_a, r_b, r_c, r_d;

    logic [md4_pkg::STEP_W-1:0]    step_rd;
    md4_pkg::t_word                x_word;
    md4_pkg::t_word                f_val;
    md4_pkg::t_word                k_val;
    md4_pkg::t_word                sum;
    md4_pkg::t_word                n_b;

    // address for the step after the one being computed
    assign step_rd = i_cmd.start ? '0 : r_step + 6'd1;
    assign o_raddr = md4_pkg::msg_index(step_rd);

    // zero fill and length words are supplied here rather than written into the buffer
    always_comb begin
        if (r_len && r_idx == md4_pkg::LEN_LO_ADDR) begin
            x_word = i_len_lo;
        end else if (r_len && r_idx == md4_pkg::LEN_HI_ADDR) begin
            x_word = i_len_hi;
        end else if ({1'b0, r_idx} >= r_fill) begin
            x_word = '0;
        end else begin
            x_word = i_rdata;
        end
    end

    always_comb begin
        unique case (r_step[5:4])
            2'd0: begin
                f_val = (r_b & r_c) | (~r_b & r_d);
                k_val = '0;
            end
            2'd1: begin
                f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k_val = md4_pkg::K_R2;
            end
            default: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = md4_pkg::K_R3;
            end
        endcase
        sum = r_a + f_val + x_word + k_val;
        n_b = md4_pkg::rotl(sum, md4_pkg::rot_amount(r_step));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_step  <= '0;
            r_chain <= {md4_pkg::INIT_D, md4_pkg::INIT_C, md4_pkg::INIT_B, md4_pkg::INIT_A};
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_d     <= '0;
        end else begin
            if (i_init) begin
                r_chain <= {md4_pkg::INIT_D, md4_pkg::INIT_C,
                            md4_pkg::INIT_B, md4_pkg::INIT_A};
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_a    <= r_chain[0];
                r_b    <= r_chain[1];
                r_c    <= r_chain[2];
                r_d    <= r_chain[3];
            end else if (r_busy && !r_fin) begin
                // target word rotates through a; order is restored every 4 steps
                r_a <= r_d;
                r_b <= n_b;
                r_c <= r_b;
                r_d <= r_c;
                if (r_step == md4_pkg::LAST_STEP) begin
                    r_fin <= 1'b1;
                end else begin
                    r_step <= r_step + 6'd1;
                end
            end else if (r_fin) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_fin      <= 1'b0;
                r_busy     <= 1'b0;
                r_step     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= o_raddr;
        if (i_cmd.start) begin
            r_fill <= i_cmd.fill_start;
            r_len  <= i_cmd.len_en;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_fin;
    assign o_chain    = r_chain;

endmodule

// ===== rtl/md4_digest.sv =====
// md4_digest: MD4 hash of a word stream; top level with control sequencer.
// Instantiates md4_buf and md4_core; depends on md4_pkg.
//
// Usage:
//   Input items on s_axis_*: tdata is one little-endian message word (first
//   byte in bits 7:0), tuser the byte count (0..4, counts only on the last
//   word; above 4 means 4), tlast marks the final word of the message.
//   Output items on m_axis_*: four digest words A, B, C, D in that order,
//   tuser the word index, tlast set on word D.
// Throughput: words that do not close a 64-byte block are taken one per
//   cycle. The word that fills a block starts a compression on the single
//   round-step unit: 48 steps and one chaining add, during which tready is
//   low.
// Closing: the last word is followed by one or two compressions before the
//   first digest word, set by where the padding and the 64-bit length land
//   in the block buffer (a last word that closes a full block counts its own
//   block as the first of the two).
// Reset: chaining words go to the MD4 initial values, byte count to zero,
//   output empty. The block buffer itself is not cleared.
// Stalls: the output register holds a digest word until taken; a new message
//   may start while word D still waits.
module md4_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP_MID,   // full data block
        S_CMP_PRE,   // last word closed a block, 0x80 goes to next one
        S_WR80,      // write the 0x80 word
        S_PLAN,      // choose one or two closing blocks
        S_CMP_OVF,   // padding block without room for the length
        S_LEN,
        S_CMP_FIN,   // block carrying the bit length
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [md4_pkg::MSG_W-1:0]       r_msg_bytes;
    logic [md4_pkg::FILL_W-1:0]      r_kk;       // first word of zero fill
    logic [md4_pkg::ADDR_W-1:0]      r_addr80;
    logic [1:0]                      r_emit_idx;
    logic                            r_m_tvalid;
    logic [31:0]                     r_m_tdata;
    logic [1:0]                      r_m_tuser;
    logic                            r_m_tlast;

    logic                            in_acc;
    logic [md4_pkg::ADDR_W-1:0]      cur_k;
    logic [2:0]                      n_clamp;
    logic                            buf_we;
    logic [md4_pkg::ADDR_W-1:0]      buf_waddr;
    md4_pkg::t_word                  buf_wdata;
    logic [md4_pkg::ADDR_W-1:0]      buf_raddr;
    md4_pkg::t_word                  buf_rdata;
    md4_pkg::t_core_cmd              core_cmd;
    md4_pkg::t_core_sts              core_sts;
    md4_pkg::t_chain                 chain;
    logic                            chain_init;
    logic                            out_load;
    md4_pkg::t_word                  len_lo;
    md4_pkg::t_word                  len_hi;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cur_k         = r_msg_bytes[5:2];
    assign n_clamp       = (s_axis_tuser > md4_pkg::FULL_BYTES) ? md4_pkg::FULL_BYTES
                                                                : s_axis_tuser;

    // message length in bits, low and high words
    assign len_lo = {r_msg_bytes[28:0], 3'b000};
    assign len_hi = r_msg_bytes[60:29];

    // buffer writes only happen while the core is idle, so no forwarding
    always_comb begin
        buf_we    = in_acc || (r_state == S_WR80);
        buf_waddr = (r_state == S_WR80) ? r_addr80 : cur_k;
        if (r_state == S_WR80) begin
            buf_wdata = md4_pkg::PAD_WORD;
        end else if (s_axis_tlast) begin
            buf_wdata = md4_pkg::pad_last(s_axis_tdata, n_clamp);
        end else begin
            buf_wdata = s_axis_tdata;
        end
    end

    always_comb begin
        core_cmd = '0;
        if (in_acc && cur_k == md4_pkg::LAST_ADDR &&
            (!s_axis_tlast || n_clamp == md4_pkg::FULL_BYTES)) begin
            core_cmd.start      = 1'b1;
            core_cmd.fill_start = md4_pkg::FILL_NONE;
        end else if (r_state == S_PLAN) begin
            core_cmd.start      = 1'b1;
            core_cmd.fill_start = r_kk;
            core_cmd.len_en     = (r_kk <= md4_pkg::LEN_START);
        end else if (r_state == S_LEN) begin
            core_cmd.start      = 1'b1;
            core_cmd.fill_start = '0;
            core_cmd.len_en     = 1'b1;
        end
    end

    assign out_load   = (r_state == S_EMIT) && (!r_m_tvalid || m_axis_tready);
    assign chain_init = out_load && (r_emit_idx == 2'd3);

    md4_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    md4_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (core_cmd),
        .i_init   (chain_init),
        .i_len_lo (len_lo),
        .i_len_hi (len_hi),
        .i_rdata  (buf_rdata),
        .o_raddr  (buf_raddr),
        .o_sts    (core_sts),
        .o_chain  (chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_msg_bytes <= '0;
            r_emit_idx  <= '0;
            r_m_tvalid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!s_axis_tlast) begin
                            r_msg_bytes <= r_msg_bytes + 61'(md4_pkg::FULL_BYTES);
                            if (cur_k == md4_pkg::LAST_ADDR) begin
                                r_state <= S_CMP_MID;
                            end
                        end else begin
                            r_msg_bytes <= r_msg_bytes + 61'(n_clamp);
                            if (n_clamp != md4_pkg::FULL_BYTES) begin
                                r_kk    <= {1'b0, cur_k} + 5'd1;
                                r_state <= S_PLAN;
                            end else if (cur_k == md4_pkg::LAST_ADDR) begin
                                r_addr80 <= '0;
                                r_kk     <= 5'd1;
                                r_state  <= S_CMP_PRE;
                            end else begin
                                r_addr80 <= cur_k + 4'd1;
                                r_kk     <= {1'b0, cur_k} + 5'd2;
                                r_state  <= S_WR80;
                            end
                        end
                    end
                end
                S_CMP_MID: begin
                    if (core_sts.done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CMP_PRE: begin
                    if (core_sts.done) begin
                        r_state <= S_WR80;
                    end
                end
                S_WR80: begin
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_state <= (r_kk > md4_pkg::LEN_START) ? S_CMP_OVF : S_CMP_FIN;
                end
                S_CMP_OVF: begin
                    if (core_sts.done) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_state <= S_CMP_FIN;
                end
                S_CMP_FIN: begin
                    if (core_sts.done) begin
                        r_emit_idx <= '0;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_m_tdata  <= chain[r_emit_idx];
                        r_m_tuser  <= r_emit_idx;
                        r_m_tlast  <= (r_emit_idx == 2'd3);
                        r_emit_idx <= r_emit_idx + 2'd1;
                        if (r_emit_idx == 2'd3) begin
                            r_msg_bytes <= '0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;
    assign m_axis_tlast  = r_m_tlast;

    // buffer must not change under a running compression
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_we |-> !core_sts.busy)
        else $error("block buffer written during compression");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_cmd.start |-> !core_sts.busy)
        else $error("compression started while core busy");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_sts.done |=> !core_sts.busy)
        else $error("core still busy after done");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !core_sts.busy)
        else $error("input ready while core busy");

endmodule
